/* hw/rtl/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes, status codes and operator priorities of the
// infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCENT  = 8'h25;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNMATCHED = 2'd2;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expr;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       last;
      logic [1:0] status;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLOSE_RD,
      ST_CLOSE_EV,
      ST_OP_RD,
      ST_OP_EV,
      ST_PUSH,
      ST_PLAIN,
      ST_FLUSH_RD,
      ST_FLUSH_EV,
      ST_ERROR,
      ST_FINAL
   } state_type;

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_PCENT) || (c == CH_CARET);
   endfunction

   function automatic logic [2:0] stacked_rank(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         CH_PLUS, CH_MINUS:           r = 3'd1;
         CH_STAR, CH_SLASH, CH_PCENT: r = 3'd2;
         CH_CARET:                    r = 3'd3;
         default:                     r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] incoming_rank(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         CH_PLUS, CH_MINUS:           r = 3'd1;
         CH_STAR, CH_SLASH, CH_PCENT: r = 3'd2;
         CH_CARET:                    r = 3'd4;
         default:                     r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream into postfix, with
// the operator stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
//
//   channel   ports                           word                      dir
//   request   req_valid req_stall req_word    symbol, end_of_expr       in
//   response  rsp_valid rsp_stall rsp_word    out_symbol, last, status  out
//
// Flow: one word in flight at a time. After its accept, a plain character holds
// req_stall high through the decode, plain, flush-read and final states; each
// stack pop adds a RAM read state and an evaluate state.
// Reset: synchronous; clear state, stack count and result slots, not the RAM.
// Stalls: absorb up to two results in the held slot and the output register;
// beyond that, rsp_stall holds the block until the output register is free.
//
module infix_to_postfix_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  itp_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output itp_pkg::rsp_word_type rsp_word
);

   itp_pkg::state_type state_ff, state_in;

   logic [7:0]               sym_ff, sym_in;
   logic                     fin_ff, fin_in;
   logic [1:0]               err_ff, err_in;
   logic [itp_pkg::CNT_W-1:0] count_ff, count_in;
   logic [itp_pkg::CNT_W-1:0] count_dec;

   // held result: its last flag is only known once the word is finished
   logic                     pend_valid_ff, pend_valid_in;
   itp_pkg::rsp_word_type    pend_ff, pend_in;

   logic                     out_valid_ff, out_valid_in;
   itp_pkg::rsp_word_type    out_ff, out_in;

   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [itp_pkg::ADDR_W-1:0] ram_rd_addr;
   logic [7:0]               ram_rd_data;

   logic                     out_free;
   logic                     can_emit;
   logic                     stack_full;
   logic                     stack_empty;
   logic                     pop_higher;

   logic                     emit_go;
   itp_pkg::rsp_word_type    emit_word;
   logic                     final_go;

   assign count_dec   = count_ff - 1'b1;
   assign stack_full  = (count_ff == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign can_emit    = !pend_valid_ff || out_free;
   assign pop_higher  = (itp_pkg::stacked_rank(ram_rd_data) >=
                         itp_pkg::incoming_rank(sym_ff));

   assign req_stall = (state_ff != itp_pkg::ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   itp_ram #(
      .WIDTH (8),
      .DEPTH (itp_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[itp_pkg::ADDR_W-1:0]),
      .wr_data (sym_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_addr = count_dec[itp_pkg::ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itp_pkg::ST_IDLE: begin
            if (req_valid) state_in = itp_pkg::ST_DECODE;
         end
         itp_pkg::ST_DECODE: begin
            if (sym_ff == itp_pkg::CH_SPACE)       state_in = itp_pkg::ST_FLUSH_RD;
            else if (sym_ff == itp_pkg::CH_LPAREN) state_in = itp_pkg::ST_PUSH;
            else if (sym_ff == itp_pkg::CH_RPAREN) state_in = itp_pkg::ST_CLOSE_RD;
            else if (itp_pkg::is_operator(sym_ff)) state_in = itp_pkg::ST_OP_RD;
            else                                   state_in = itp_pkg::ST_PLAIN;
         end
         itp_pkg::ST_CLOSE_RD: begin
            state_in = stack_empty ? itp_pkg::ST_ERROR : itp_pkg::ST_CLOSE_EV;
         end
         itp_pkg::ST_CLOSE_EV: begin
            if (ram_rd_data == itp_pkg::CH_LPAREN) state_in = itp_pkg::ST_FLUSH_RD;
            else if (can_emit)                     state_in = itp_pkg::ST_CLOSE_RD;
         end
         itp_pkg::ST_OP_RD: begin
            state_in = stack_empty ? itp_pkg::ST_PUSH : itp_pkg::ST_OP_EV;
         end
         itp_pkg::ST_OP_EV: begin
            if (!pop_higher)   state_in = itp_pkg::ST_PUSH;
            else if (can_emit) state_in = itp_pkg::ST_OP_RD;
         end
         itp_pkg::ST_PUSH: begin
            state_in = stack_full ? itp_pkg::ST_ERROR : itp_pkg::ST_FLUSH_RD;
         end
         itp_pkg::ST_PLAIN: begin
            if (can_emit) state_in = itp_pkg::ST_FLUSH_RD;
         end
         itp_pkg::ST_FLUSH_RD: begin
            state_in = (fin_ff && !stack_empty) ? itp_pkg::ST_FLUSH_EV
                                                : itp_pkg::ST_FINAL;
         end
         itp_pkg::ST_FLUSH_EV: begin
            if (can_emit) state_in = itp_pkg::ST_FLUSH_RD;
         end
         itp_pkg::ST_ERROR: begin
            if (can_emit) state_in = itp_pkg::ST_FINAL;
         end
         itp_pkg::ST_FINAL: begin
            if (out_free) state_in = itp_pkg::ST_IDLE;
         end
         default: begin
            state_in = itp_pkg::ST_IDLE;
         end
      endcase
   end

   // stack, emit and control actions
   always_comb begin
      sym_in    = sym_ff;
      fin_in    = fin_ff;
      err_in    = err_ff;
      count_in  = count_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      emit_go   = 1'b0;
      final_go  = 1'b0;
      emit_word = '{out_symbol: ram_rd_data, last: 1'b0, status: itp_pkg::STATUS_OK};
      case (state_ff)
         itp_pkg::ST_IDLE: begin
            if (req_valid) begin
               sym_in = req_word.symbol;
               fin_in = req_word.end_of_expr;
            end
         end
         itp_pkg::ST_CLOSE_RD: begin
            if (stack_empty) err_in = itp_pkg::STATUS_UNMATCHED;
            else             ram_rd_en = 1'b1;
         end
         itp_pkg::ST_CLOSE_EV: begin
            if (ram_rd_data == itp_pkg::CH_LPAREN) begin
               count_in = count_dec;  // drop the matching '('
            end else if (can_emit) begin
               emit_go  = 1'b1;
               count_in = count_dec;
            end
         end
         itp_pkg::ST_OP_RD: begin
            if (!stack_empty) ram_rd_en = 1'b1;
         end
         itp_pkg::ST_OP_EV: begin
            if (pop_higher && can_emit) begin
               emit_go  = 1'b1;
               count_in = count_dec;
            end
         end
         itp_pkg::ST_PUSH: begin
            if (stack_full) begin
               err_in = itp_pkg::STATUS_OVERFLOW;
            end else begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         itp_pkg::ST_PLAIN: begin
            emit_word.out_symbol = sym_ff;
            emit_go = can_emit;
         end
         itp_pkg::ST_FLUSH_RD: begin
            if (fin_ff && !stack_empty) ram_rd_en = 1'b1;
         end
         itp_pkg::ST_FLUSH_EV: begin
            if (can_emit) begin
               emit_go  = 1'b1;
               count_in = count_dec;
            end
         end
         itp_pkg::ST_ERROR: begin
            emit_word.out_symbol = sym_ff;
            emit_word.status     = err_ff;
            if (can_emit) begin
               emit_go  = 1'b1;
               fin_in   = 1'b1;   // error result always closes the expression
               count_in = '0;
            end
         end
         itp_pkg::ST_FINAL: begin
            final_go = out_free;
         end
         default: begin
         end
      endcase
   end

   // result slots: a new result pushes the held one out as not-last;
   // the end of the word releases the held one with last = end flag, else at an end a last NUL
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (emit_go) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_valid_in = 1'b1;
         end
         pend_in       = emit_word;
         pend_valid_in = 1'b1;
      end else if (final_go) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_in.last  = fin_ff;
            out_valid_in = 1'b1;
         end else if (fin_ff) begin
            out_in       = '{out_symbol: itp_pkg::CH_NUL, last: 1'b1,
                             status: itp_pkg::STATUS_OK};
            out_valid_in = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itp_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      sym_ff  <= sym_in;
      fin_ff  <= fin_in;
      err_ff  <= err_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

endmodule

/* hw/rtl/itp_ram.sv */
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last word read while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/itp_checker.sv */
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks of the infix to postfix converter, bound to the top.
// ----------------------------------------------------------------------------
module itp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input itp_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input itp_pkg::rsp_word_type rsp_word
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   // one word in flight: an accept is followed by a busy cycle
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted back to back");

   // an error result always closes the expression
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != itp_pkg::STATUS_OK) |-> rsp_word.last)
      else $error("error result not marked last");

   // no status code beyond the defined ones
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status == itp_pkg::STATUS_OK) ||
                    (rsp_word.status == itp_pkg::STATUS_OVERFLOW) ||
                    (rsp_word.status == itp_pkg::STATUS_UNMATCHED))
      else $error("undefined status code");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

/* sim/tb_infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Self-checking bench for the shunting-yard converter: directed words from a
// short table, then plain characters under a response hold-off, then random
// expressions under four idling phases. Every accepted request word runs
// through a local shadow of the operator stack. Every response word is
// checked field by field against the oldest predicted postfix word.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;

   localparam int CYCLE_LIMIT     = 2000000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_WORDS    = 400;
   localparam int DRAIN_CYCLES    = 40;

   // One row of the directed table. Where typed is set, the row yields exactly
   // one response word and that word is written out by hand.
   typedef struct {
      logic [7:0]            symbol;
      logic                  eoe;
      int                    copies;
      bit                    typed;
      itp_pkg::rsp_word_type typed_word;
   } dir_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   itp_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   itp_pkg::rsp_word_type rsp_word;

   // Shadow of the operator stack and the words still owed by the block
   logic [7:0]            held_ops [itp_pkg::STACK_DEPTH];
   int                    held_count = 0;
   itp_pkg::rsp_word_type step_words[$];
   itp_pkg::rsp_word_type postfix_expected[$];

   dir_row_type           directed_rows[$];
   itp_pkg::req_word_type burst[$];

   int cycle_count   = 0;
   int mismatches    = 0;
   int gap_pct       = 0;
   int stall_pct     = 0;
   int hold_off_req  = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   infix_to_postfix_converter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow converter
   // ------------------------------------------------------------------------

   // Binding strength of an operator; caret binds tighter arriving than
   // stacked, which makes a chain of carets group to the right.
   function automatic int op_rank(input logic [7:0] c, input bit arriving);
      case (c)
         itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:                    return 1;
         itp_pkg::CH_STAR, itp_pkg::CH_SLASH, itp_pkg::CH_PCENT: return 2;
         itp_pkg::CH_CARET:                            return arriving ? 4 : 3;
         default:                                                return 0;
      endcase
   endfunction

   function automatic void put_char(input logic [7:0] c, input logic lst,
                                    input logic [1:0] st);
      itp_pkg::rsp_word_type r;
      r.out_symbol = c;
      r.last       = lst;
      r.status     = st;
      step_words.push_back(r);
   endfunction

   // Work out the postfix words caused by one request word into step_words
   // and advance the shadow stack.
   function automatic void convert_symbol(input itp_pkg::req_word_type w);
      logic [7:0] sym;
      bit         pushing;
      bit         matched;
      sym     = w.symbol;
      pushing = 1'b0;
      matched = 1'b0;
      step_words.delete();
      case (sym)
         itp_pkg::CH_SPACE: ;
         itp_pkg::CH_LPAREN: pushing = 1'b1;
         itp_pkg::CH_RPAREN: begin
            // pop down to the matching open bracket, which is dropped
            while (held_count > 0 && !matched) begin
               held_count--;
               if (held_ops[held_count] == itp_pkg::CH_LPAREN)
                  matched = 1'b1;
               else
                  put_char(held_ops[held_count], 1'b0, itp_pkg::STATUS_OK);
            end
            if (!matched) begin
               put_char(sym, 1'b1, itp_pkg::STATUS_UNMATCHED);
               held_count = 0;
               return;
            end
         end
         itp_pkg::CH_PLUS, itp_pkg::CH_MINUS, itp_pkg::CH_STAR,
         itp_pkg::CH_SLASH, itp_pkg::CH_PCENT, itp_pkg::CH_CARET: begin
            while (held_count > 0 &&
                   op_rank(held_ops[held_count - 1], 1'b0) >= op_rank(sym, 1'b1)) begin
               held_count--;
               put_char(held_ops[held_count], 1'b0, itp_pkg::STATUS_OK);
            end
            pushing = 1'b1;
         end
         default: put_char(sym, 1'b0, itp_pkg::STATUS_OK);
      endcase
      if (pushing) begin
         // a full stack aborts the expression: no flush follows
         if (held_count == itp_pkg::STACK_DEPTH) begin
            put_char(sym, 1'b1, itp_pkg::STATUS_OVERFLOW);
            held_count = 0;
            return;
         end
         held_ops[held_count] = sym;
         held_count++;
      end
      if (w.end_of_expr) begin
         while (held_count > 0) begin
            held_count--;
            put_char(held_ops[held_count], 1'b0, itp_pkg::STATUS_OK);
         end
         if (step_words.size() == 0)
            put_char(itp_pkg::CH_NUL, 1'b1, itp_pkg::STATUS_OK);
         else
            step_words[$].last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("cycle %0d: %s got 0x%0h, wanted 0x%0h", cycle_count, what, got, want);
   endtask

   // Compare each response word taken by the bench with the oldest prediction
   always @(posedge clock) begin
      itp_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (postfix_expected.size() == 0) begin
            report_mismatch("unexpected word, symbol", rsp_word.out_symbol, 0);
         end else begin
            want = postfix_expected.pop_front();
            if (rsp_word.out_symbol !== want.out_symbol)
               report_mismatch("out_symbol", rsp_word.out_symbol, want.out_symbol);
            if (rsp_word.last !== want.last)
               report_mismatch("last", rsp_word.last, want.last);
            if (rsp_word.status !== want.status)
               report_mismatch("status", rsp_word.status, want.status);
         end
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("infix_to_postfix_converter: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Response side: random stall, or a long hold-off on request from the
   // main flow. The hold-off is counted here so that the sender keeps going.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_seen != hold_off_req) begin
         hold_seen = hold_off_req;
         hold_left = HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one word, called at a rising edge. Idle first if the phase asks for
   // it, hold the word until taken, then predict. Valid is left high so that
   // the next word follows back to back.
   task automatic send_word(input itp_pkg::req_word_type w, input bit typed,
                            input itp_pkg::rsp_word_type typed_word);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      convert_symbol(w);
      if (typed)
         postfix_expected.push_back(typed_word);
      else
         foreach (step_words[i])
            postfix_expected.push_back(step_words[i]);
   endtask

   function automatic void add_row(input logic [7:0] sym, input logic eoe,
                                   input int copies, input bit typed,
                                   input itp_pkg::rsp_word_type typed_word);
      dir_row_type r;
      r.symbol     = sym;
      r.eoe        = eoe;
      r.copies     = copies;
      r.typed      = typed;
      r.typed_word = typed_word;
      directed_rows.push_back(r);
   endfunction

   function automatic bit is_special(input logic [7:0] c);
      case (c)
         itp_pkg::CH_LPAREN, itp_pkg::CH_RPAREN, itp_pkg::CH_SPACE,
         itp_pkg::CH_PLUS, itp_pkg::CH_MINUS, itp_pkg::CH_STAR,
         itp_pkg::CH_SLASH, itp_pkg::CH_PCENT, itp_pkg::CH_CARET: return 1'b1;
         default:                                                 return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] pick_operand();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (is_special(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 5))
         0:       return itp_pkg::CH_PLUS;
         1:       return itp_pkg::CH_MINUS;
         2:       return itp_pkg::CH_STAR;
         3:       return itp_pkg::CH_SLASH;
         4:       return itp_pkg::CH_PCENT;
         default: return itp_pkg::CH_CARET;
      endcase
   endfunction

   function automatic void add_char(input logic [7:0] c, input logic eoe);
      itp_pkg::req_word_type w;
      w.symbol      = c;
      w.end_of_expr = eoe;
      burst.push_back(w);
   endfunction

   // Well-formed expression with random operands, operators, brackets and
   // spaces; now and then leave brackets open so that they get flushed.
   function automatic void build_expression();
      int terms;
      int depth;
      terms = $urandom_range(1, 8);
      depth = 0;
      for (int t = 0; t < terms; t++) begin
         while (depth < 6 && $urandom_range(0, 3) == 0) begin
            add_char(itp_pkg::CH_LPAREN, 1'b0);
            depth++;
         end
         if ($urandom_range(0, 5) == 0)
            add_char(itp_pkg::CH_SPACE, 1'b0);
         add_char(pick_operand(), 1'b0);
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            add_char(itp_pkg::CH_RPAREN, 1'b0);
            depth--;
         end
         if (t < terms - 1)
            add_char(pick_operator(), 1'b0);
      end
      if ($urandom_range(0, 4) != 0)
         while (depth > 0) begin
            add_char(itp_pkg::CH_RPAREN, 1'b0);
            depth--;
         end
      burst[$].end_of_expr = 1'b1;
   endfunction

   // Noise: any byte, half of them picked from the special characters, with
   // end marks dropped at random.
   function automatic void build_noise();
      int n;
      logic [7:0] c;
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 0)
            c = 8'($urandom_range(0, 255));
         else
            case ($urandom_range(0, 3))
               0:       c = itp_pkg::CH_LPAREN;
               1:       c = itp_pkg::CH_RPAREN;
               2:       c = itp_pkg::CH_SPACE;
               default: c = pick_operator();
            endcase
         add_char(c, ($urandom_range(0, 7) == 0));
      end
      if ($urandom_range(0, 1) == 0)
         burst[$].end_of_expr = 1'b1;
   endfunction

   // Deep nesting or a long caret chain, run close to or past a full stack
   function automatic void build_deep();
      int n;
      n = $urandom_range(itp_pkg::STACK_DEPTH - 2, itp_pkg::STACK_DEPTH + 2);
      if ($urandom_range(0, 1) == 0) begin
         for (int i = 0; i < n; i++)
            add_char(itp_pkg::CH_LPAREN, 1'b0);
      end else begin
         for (int i = 0; i < n; i++) begin
            add_char(pick_operand(), 1'b0);
            add_char(itp_pkg::CH_CARET, 1'b0);
         end
      end
      add_char(pick_operand(), 1'b1);
   endfunction

   // ------------------------------------------------------------------------
   // Main flow
   // ------------------------------------------------------------------------
   initial begin
      itp_pkg::req_word_type w;
      int                    sent;
      int                    r;

      // Directed table. Typed rows are those whose answer is plain: empty end,
      // lone closing bracket, extreme bytes, full stack, lone operator at end.
      add_row(itp_pkg::CH_SPACE,  1'b1, 1, 1'b1,
              '{itp_pkg::CH_NUL, 1'b1, itp_pkg::STATUS_OK});
      add_row(itp_pkg::CH_RPAREN, 1'b0, 1, 1'b1,
              '{itp_pkg::CH_RPAREN, 1'b1, itp_pkg::STATUS_UNMATCHED});
      add_row(8'hFF,              1'b1, 1, 1'b1, '{8'hFF, 1'b1, itp_pkg::STATUS_OK});
      add_row(8'h00,              1'b1, 1, 1'b1, '{8'h00, 1'b1, itp_pkg::STATUS_OK});
      // a + (b - c) * d ^ e ^ f / g % h
      add_row("a",                1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_PLUS,   1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_LPAREN, 1'b0, 1, 1'b0, '0);
      add_row("b",                1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_MINUS,  1'b0, 1, 1'b0, '0);
      add_row("c",                1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_RPAREN, 1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_STAR,   1'b0, 1, 1'b0, '0);
      add_row("d",                1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_CARET,  1'b0, 1, 1'b0, '0);
      add_row("e",                1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_CARET,  1'b0, 1, 1'b0, '0);
      add_row("f",                1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_SLASH,  1'b0, 1, 1'b0, '0);
      add_row("g",                1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_PCENT,  1'b0, 1, 1'b0, '0);
      add_row("h",                1'b1, 1, 1'b0, '0);
      // open bracket left over at the end is flushed out
      add_row(itp_pkg::CH_LPAREN, 1'b0, 1, 1'b0, '0);
      add_row("x",                1'b1, 1, 1'b0, '0);
      // closing bracket that pops an operator and then finds no match
      add_row(itp_pkg::CH_PLUS,   1'b0, 1, 1'b0, '0);
      add_row(itp_pkg::CH_RPAREN, 1'b0, 1, 1'b0, '0);
      // fill the stack, then one push too many
      add_row(itp_pkg::CH_LPAREN, 1'b0, itp_pkg::STACK_DEPTH, 1'b0, '0);
      add_row(itp_pkg::CH_PLUS,   1'b0, 1, 1'b1,
              '{itp_pkg::CH_PLUS, 1'b1, itp_pkg::STATUS_OVERFLOW});
      // end mark on an operator with nothing stacked
      add_row(itp_pkg::CH_MINUS,  1'b1, 1, 1'b1,
              '{itp_pkg::CH_MINUS, 1'b1, itp_pkg::STATUS_OK});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         for (int k = 0; k < directed_rows[i].copies; k++) begin
            w.symbol      = directed_rows[i].symbol;
            w.end_of_expr = directed_rows[i].eoe;
            send_word(w, directed_rows[i].typed, directed_rows[i].typed_word);
         end

      // Hold off the response side while plain characters keep arriving, so
      // that the block backs up and stalls its request side.
      hold_off_req = hold_off_req + 1;
      burst.delete();
      for (int i = 0; i < 48; i++)
         add_char(pick_operand(), (i == 47));
      foreach (burst[i])
         send_word(burst[i], 1'b0, '0);

      // Random part over four idling phases: none, sender idle, receiver
      // stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 86; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 86; end
            default: begin gap_pct = 31; stall_pct = 31; end
         endcase
         sent = 0;
         while (sent < RANDOM_WORDS / 4) begin
            burst.delete();
            r = $urandom_range(0, 99);
            if (r < 70)
               build_expression();
            else if (r < 88)
               build_noise();
            else
               build_deep();
            foreach (burst[i]) begin
               send_word(burst[i], 1'b0, '0);
               // spaces are dropped by the block and do not count
               if (burst[i].symbol != itp_pkg::CH_SPACE)
                  sent++;
            end
         end
      end

      req_valid <= 1'b0;
      stall_pct = 31;

      // drain, then give the block a little longer to show any stray word
      while (postfix_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("infix_to_postfix_converter: match");
      else
         $display("infix_to_postfix_converter: mismatch");
      $finish;
   end

endmodule
